### rtl/rti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * Q_W;
    localparam int DIV_NUM_W = Q_W + FRAC_W;
    localparam int DIV_DEN_W = Q_W;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam q_t ONE_Q   = 32'sd65536;
    localparam q_t PAR_LIM = 32'sd655;
    localparam q_t Q_MAX   = 32'sh7fffffff;
    localparam q_t Q_MIN   = 32'sh80000000;

    typedef enum logic [1:0] {
        CODE_MISS   = 2'd0,
        CODE_INSIDE = 2'd1,
        CODE_PLANE  = 2'd2,
        CODE_DEGEN  = 2'd3
    } hit_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORG_X = 3'd0,
        REG_ORG_Y = 3'd1,
        REG_ORG_Z = 3'd2,
        REG_DIR_X = 3'd3,
        REG_DIR_Y = 3'd4,
        REG_DIR_Z = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        q_t vert0_x;
        q_t vert0_y;
        q_t vert0_z;
        q_t vert1_x;
        q_t vert1_y;
        q_t vert1_z;
        q_t vert2_x;
        q_t vert2_y;
        q_t vert2_z;
    } face_t;

    typedef struct packed {
        hit_code_t hit_code;
        q_t        hit_x;
        q_t        hit_y;
        q_t        hit_z;
        q_t        param_s;
        q_t        param_t;
    } result_t;

    function automatic prod_t ext_q(input q_t x);
        return prod_t'(x);
    endfunction

    function automatic prod_t mul_q(input q_t a, input q_t b);
        return a * b;
    endfunction

    function automatic q_t sat_q(input prod_t x);
        q_t r;
        if (x > ext_q(Q_MAX))
            r = Q_MAX;
        else if (x < ext_q(Q_MIN))
            r = Q_MIN;
        else
            r = q_t'(x[Q_W-1:0]);
        return r;
    endfunction

    // magnitude, exact for the most negative value
    function automatic logic [Q_W-1:0] mag_q(input q_t x);
        logic [Q_W-1:0] r;
        if (x[Q_W-1])
            r = -x[Q_W-1:0];
        else
            r = x[Q_W-1:0];
        return r;
    endfunction

    // sum of three floored Q16.16 products, saturated
    function automatic q_t dot_q(input prod_t a, input prod_t b, input prod_t c);
        return sat_q((a >>> FRAC_W) + (b >>> FRAC_W) + (c >>> FRAC_W));
    endfunction

    function automatic q_t diff_q(input prod_t a, input prod_t b);
        return sat_q((a >>> FRAC_W) - (b >>> FRAC_W));
    endfunction

    // signed, saturated result from quotient magnitude and sign
    function automatic q_t sat_div(input logic [DIV_NUM_W-1:0] mag, input logic neg);
        logic [DIV_NUM_W-1:0] lim;
        q_t                   r;
        lim = DIV_NUM_W'(mag_q(Q_MIN));
        if (neg) begin
            if (mag > lim)
                r = Q_MIN;
            else
                r = q_t'(-mag[Q_W-1:0]);
        end
        else begin
            if (mag > DIV_NUM_W'(Q_MAX))
                r = Q_MAX;
            else
                r = q_t'(mag[Q_W-1:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/ray_triangle_intersect.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                    Word
// -------   -----------------------------------------  ------------------------
// cfg       cfg_valid / cfg_ready, cfg_index, cfg_data  ray origin and direction
// face      face_valid / face_ready, face              three vertices, Q16.16
// result    result_valid / result_ready, result        hit code, point, s, t
//
// One face word per cycle while face_ready is high. The path runs through
// the two 48-stage pipelined dividers (ray parameter, then s and t sharing
// one denominator) and the arithmetic stages S1..S7, S8..S16, S17 and S18.
// Reset clears the ray registers to zero and empties every valid bit.
// The pipeline advances as a whole; an output register plus one skid word
// absorb a stalled consumer, so face_ready only drops once both are full.
module ray_triangle_intersect (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rti_pkg::Q_W-1:0]         cfg_data,
    input  wire logic                            face_valid,
    output logic                                 face_ready,
    input  wire rti_pkg::face_t                  face,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output rti_pkg::result_t                     result
);

    typedef rti_pkg::q_t    [2:0] vec_t;
    typedef rti_pkg::prod_t [2:0] pvec_t;

    typedef struct packed {
        vec_t u;
        vec_t v;
        vec_t p0;
    } geo_t;

    // carried through the ray divider and the hit point stages
    typedef struct packed {
        geo_t        g;
        rti_pkg::q_t uu;
        rti_pkg::q_t uv;
        rti_pkg::q_t vv;
        rti_pkg::q_t den_st;
        logic        degen;
        logic        par;
        logic        plane;
        logic        qneg;
        logic        behind;
        vec_t        hit;
    } mid_t;

    // carried through the s / t divider
    typedef struct packed {
        vec_t hit;
        logic degen;
        logic par;
        logic plane;
        logic behind;
        logic dzero;
        logic neg_s;
        logic neg_t;
    } st_t;

    localparam int F = rti_pkg::FRAC_W;

    // ray registers
    vec_t org_reg;
    vec_t dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg <= '0;
            dir_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rti_pkg::REG_ORG_X: org_reg[0] <= cfg_data;
                rti_pkg::REG_ORG_Y: org_reg[1] <= cfg_data;
                rti_pkg::REG_ORG_Z: org_reg[2] <= cfg_data;
                rti_pkg::REG_DIR_X: dir_reg[0] <= cfg_data;
                rti_pkg::REG_DIR_Y: dir_reg[1] <= cfg_data;
                rti_pkg::REG_DIR_Z: dir_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // global advance: held only while the skid word is occupied
    logic en;
    logic sk_v_reg;
    logic oq_v_reg;

    assign en         = !sk_v_reg;
    assign face_ready = en;

    vec_t p0_in, p1_in, p2_in;
    assign p0_in = {face.vert0_z, face.vert0_y, face.vert0_x};
    assign p1_in = {face.vert1_z, face.vert1_y, face.vert1_x};
    assign p2_in = {face.vert2_z, face.vert2_y, face.vert2_x};

    // front stages S1..S7
    logic [6:0]       pre_v_reg;
    geo_t             g1_reg, g2_reg, g3_reg, g4_reg, g5_reg, g6_reg;
    vec_t             w01_reg, w02_reg, w03_reg;
    rti_pkg::prod_t   m2_reg [6];
    vec_t             n3_reg;
    logic             degen3_reg, degen4_reg, degen5_reg, degen6_reg;
    pvec_t            nw4_reg, nd4_reg, uu4_reg, uv4_reg, vv4_reg;
    rti_pkg::q_t      a5_reg, b5_reg, uu5_reg, uv5_reg, vv5_reg;
    rti_pkg::q_t      a6_reg, b6_reg, uu6_reg, uv6_reg, vv6_reg;
    logic             par6_reg, plane6_reg;
    rti_pkg::prod_t   pp1_6_reg, pp2_6_reg;
    logic [rti_pkg::DIV_NUM_W-1:0] num7_reg;
    logic [rti_pkg::DIV_DEN_W-1:0] den7_reg;
    mid_t             mid7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_v_reg <= '0;
        else if (en)
            pre_v_reg <= {pre_v_reg[5:0], face_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // S1: edge vectors and origin offset
            for (int i = 0; i < 3; i++)
            begin
                g1_reg.u[i]  <= rti_pkg::sat_q(rti_pkg::ext_q(p1_in[i]) - rti_pkg::ext_q(p0_in[i]));
                g1_reg.v[i]  <= rti_pkg::sat_q(rti_pkg::ext_q(p2_in[i]) - rti_pkg::ext_q(p0_in[i]));
                w01_reg[i]   <= rti_pkg::sat_q(rti_pkg::ext_q(org_reg[i]) - rti_pkg::ext_q(p0_in[i]));
            end
            g1_reg.p0 <= p0_in;

            // S2: cross product terms
            g2_reg    <= g1_reg;
            w02_reg   <= w01_reg;
            m2_reg[0] <= rti_pkg::mul_q(g1_reg.u[1], g1_reg.v[2]);
            m2_reg[1] <= rti_pkg::mul_q(g1_reg.u[2], g1_reg.v[1]);
            m2_reg[2] <= rti_pkg::mul_q(g1_reg.u[2], g1_reg.v[0]);
            m2_reg[3] <= rti_pkg::mul_q(g1_reg.u[0], g1_reg.v[2]);
            m2_reg[4] <= rti_pkg::mul_q(g1_reg.u[0], g1_reg.v[1]);
            m2_reg[5] <= rti_pkg::mul_q(g1_reg.u[1], g1_reg.v[0]);

            // S3: normal; exact cross product zero means degenerate
            g3_reg     <= g2_reg;
            w03_reg    <= w02_reg;
            n3_reg[0]  <= rti_pkg::sat_q((m2_reg[0] - m2_reg[1]) >>> F);
            n3_reg[1]  <= rti_pkg::sat_q((m2_reg[2] - m2_reg[3]) >>> F);
            n3_reg[2]  <= rti_pkg::sat_q((m2_reg[4] - m2_reg[5]) >>> F);
            degen3_reg <= (m2_reg[0] == m2_reg[1]) && (m2_reg[2] == m2_reg[3])
                          && (m2_reg[4] == m2_reg[5]);

            // S4: plane products and edge Gram terms
            g4_reg     <= g3_reg;
            degen4_reg <= degen3_reg;
            for (int i = 0; i < 3; i++)
            begin
                nw4_reg[i] <= rti_pkg::mul_q(n3_reg[i], w03_reg[i]);
                nd4_reg[i] <= rti_pkg::mul_q(n3_reg[i], dir_reg[i]);
                uu4_reg[i] <= rti_pkg::mul_q(g3_reg.u[i], g3_reg.u[i]);
                uv4_reg[i] <= rti_pkg::mul_q(g3_reg.u[i], g3_reg.v[i]);
                vv4_reg[i] <= rti_pkg::mul_q(g3_reg.v[i], g3_reg.v[i]);
            end

            // S5: dot products
            g5_reg     <= g4_reg;
            degen5_reg <= degen4_reg;
            a5_reg     <= rti_pkg::sat_q(-((nw4_reg[0] >>> F) + (nw4_reg[1] >>> F)
                                           + (nw4_reg[2] >>> F)));
            b5_reg     <= rti_pkg::dot_q(nd4_reg[0], nd4_reg[1], nd4_reg[2]);
            uu5_reg    <= rti_pkg::dot_q(uu4_reg[0], uu4_reg[1], uu4_reg[2]);
            uv5_reg    <= rti_pkg::dot_q(uv4_reg[0], uv4_reg[1], uv4_reg[2]);
            vv5_reg    <= rti_pkg::dot_q(vv4_reg[0], vv4_reg[1], vv4_reg[2]);

            // S6: parallel test, denominator products
            g6_reg     <= g5_reg;
            degen6_reg <= degen5_reg;
            a6_reg     <= a5_reg;
            b6_reg     <= b5_reg;
            uu6_reg    <= uu5_reg;
            uv6_reg    <= uv5_reg;
            vv6_reg    <= vv5_reg;
            par6_reg   <= (b5_reg > -rti_pkg::PAR_LIM) && (b5_reg < rti_pkg::PAR_LIM);
            plane6_reg <= (a5_reg == '0);
            pp1_6_reg  <= rti_pkg::mul_q(uv5_reg, uv5_reg);
            pp2_6_reg  <= rti_pkg::mul_q(uu5_reg, vv5_reg);

            // S7: operands for r = a / b
            num7_reg        <= {rti_pkg::mag_q(a6_reg), {F{1'b0}}};
            den7_reg        <= rti_pkg::mag_q(b6_reg);
            mid7_reg.g      <= g6_reg;
            mid7_reg.uu     <= uu6_reg;
            mid7_reg.uv     <= uv6_reg;
            mid7_reg.vv     <= vv6_reg;
            mid7_reg.den_st <= rti_pkg::diff_q(pp1_6_reg, pp2_6_reg);
            mid7_reg.degen  <= degen6_reg;
            mid7_reg.par    <= par6_reg;
            mid7_reg.plane  <= plane6_reg;
            mid7_reg.qneg   <= a6_reg[rti_pkg::Q_W-1] ^ b6_reg[rti_pkg::Q_W-1];
            mid7_reg.behind <= 1'b0;
            mid7_reg.hit    <= '0;
        end
    end

    // ray parameter divider
    logic                                     r_valid;
    logic [0:0][rti_pkg::DIV_NUM_W-1:0]       r_quot;
    mid_t                                     r_sb;

    rti_div #(
        .NUM_W (rti_pkg::DIV_NUM_W),
        .DEN_W (rti_pkg::DIV_DEN_W),
        .LANES (1),
        .SB_W  ($bits(mid_t))
    ) u_div_r (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid      (pre_v_reg[6]),
        .num        (num7_reg),
        .den        (den7_reg),
        .sb         (mid7_reg),
        .done_valid (r_valid),
        .quot       (r_quot),
        .done_sb    (r_sb)
    );

    // middle stages S8..S16
    logic [8:0]     mid_v_reg;
    mid_t           mid_reg  [8];
    mid_t           mid_next [8];
    rti_pkg::q_t    r8_reg;
    pvec_t          rd9_reg;
    vec_t           w11_reg;
    pvec_t          wu12_reg, wv12_reg;
    rti_pkg::q_t    wu13_reg, wv13_reg;
    rti_pkg::prod_t p14_reg [4];
    rti_pkg::q_t    sn15_reg, tn15_reg;
    logic [1:0][rti_pkg::DIV_NUM_W-1:0] num16_reg;
    logic [rti_pkg::DIV_DEN_W-1:0]      den16_reg;
    st_t            st16_reg;

    always_comb
    begin
        mid_next[0] = r_sb;
        for (int k = 1; k < 8; k++)
            mid_next[k] = mid_reg[k-1];
        mid_next[1].behind = r8_reg[rti_pkg::Q_W-1];
        for (int i = 0; i < 3; i++)
            mid_next[2].hit[i] = rti_pkg::sat_q(rti_pkg::ext_q(org_reg[i]) + (rd9_reg[i] >>> F));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_v_reg <= '0;
        else if (en)
            mid_v_reg <= {mid_v_reg[7:0], r_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 8; k++)
                mid_reg[k] <= mid_next[k];

            r8_reg <= rti_pkg::sat_div(r_quot[0], r_sb.qneg);

            for (int i = 0; i < 3; i++)
            begin
                rd9_reg[i]  <= rti_pkg::mul_q(r8_reg, dir_reg[i]);
                w11_reg[i]  <= rti_pkg::sat_q(rti_pkg::ext_q(mid_reg[2].hit[i])
                                              - rti_pkg::ext_q(mid_reg[2].g.p0[i]));
                wu12_reg[i] <= rti_pkg::mul_q(w11_reg[i], mid_reg[3].g.u[i]);
                wv12_reg[i] <= rti_pkg::mul_q(w11_reg[i], mid_reg[3].g.v[i]);
            end

            wu13_reg <= rti_pkg::dot_q(wu12_reg[0], wu12_reg[1], wu12_reg[2]);
            wv13_reg <= rti_pkg::dot_q(wv12_reg[0], wv12_reg[1], wv12_reg[2]);

            p14_reg[0] <= rti_pkg::mul_q(mid_reg[5].uv, wv13_reg);
            p14_reg[1] <= rti_pkg::mul_q(mid_reg[5].vv, wu13_reg);
            p14_reg[2] <= rti_pkg::mul_q(mid_reg[5].uv, wu13_reg);
            p14_reg[3] <= rti_pkg::mul_q(mid_reg[5].uu, wv13_reg);

            sn15_reg <= rti_pkg::diff_q(p14_reg[0], p14_reg[1]);
            tn15_reg <= rti_pkg::diff_q(p14_reg[2], p14_reg[3]);

            // S16: operands for s and t over the shared denominator
            num16_reg[0]   <= {rti_pkg::mag_q(sn15_reg), {F{1'b0}}};
            num16_reg[1]   <= {rti_pkg::mag_q(tn15_reg), {F{1'b0}}};
            den16_reg      <= rti_pkg::mag_q(mid_reg[7].den_st);
            st16_reg.hit   <= mid_reg[7].hit;
            st16_reg.degen <= mid_reg[7].degen;
            st16_reg.par   <= mid_reg[7].par;
            st16_reg.plane <= mid_reg[7].plane;
            st16_reg.behind <= mid_reg[7].behind;
            st16_reg.dzero <= (mid_reg[7].den_st == '0);
            st16_reg.neg_s <= sn15_reg[rti_pkg::Q_W-1] ^ mid_reg[7].den_st[rti_pkg::Q_W-1];
            st16_reg.neg_t <= tn15_reg[rti_pkg::Q_W-1] ^ mid_reg[7].den_st[rti_pkg::Q_W-1];
        end
    end

    // s / t divider
    logic                                 st_valid;
    logic [1:0][rti_pkg::DIV_NUM_W-1:0]   st_quot;
    st_t                                  st_sb;

    rti_div #(
        .NUM_W (rti_pkg::DIV_NUM_W),
        .DEN_W (rti_pkg::DIV_DEN_W),
        .LANES (2),
        .SB_W  ($bits(st_t))
    ) u_div_st (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid      (mid_v_reg[8]),
        .num        (num16_reg),
        .den        (den16_reg),
        .sb         (st16_reg),
        .done_valid (st_valid),
        .quot       (st_quot),
        .done_sb    (st_sb)
    );

    // tail stages S17 (saturate) and S18 (classify)
    logic [1:0]       post_v_reg;
    rti_pkg::q_t      s17_reg, t17_reg;
    st_t              st17_reg;
    rti_pkg::result_t res18_reg;
    rti_pkg::result_t res18_next;

    always_comb
    begin
        res18_next.hit_code = rti_pkg::CODE_MISS;
        res18_next.hit_x    = st17_reg.hit[0];
        res18_next.hit_y    = st17_reg.hit[1];
        res18_next.hit_z    = st17_reg.hit[2];
        res18_next.param_s  = s17_reg;
        res18_next.param_t  = t17_reg;
        if (st17_reg.degen || st17_reg.par || st17_reg.behind)
        begin
            // hit point never reached
            res18_next.hit_x   = '0;
            res18_next.hit_y   = '0;
            res18_next.hit_z   = '0;
            res18_next.param_s = '0;
            res18_next.param_t = '0;
            if (st17_reg.degen)
                res18_next.hit_code = rti_pkg::CODE_DEGEN;
            else if (st17_reg.par && st17_reg.plane)
                res18_next.hit_code = rti_pkg::CODE_PLANE;
        end
        else if (st17_reg.dzero)
        begin
            res18_next.param_s = '0;
            res18_next.param_t = '0;
        end
        else if (s17_reg < 0 || s17_reg > rti_pkg::ONE_Q)
            res18_next.param_t = '0;
        else if (!(t17_reg < 0 || (34'(s17_reg) + 34'(t17_reg)) > 34'(rti_pkg::ONE_Q)))
            res18_next.hit_code = rti_pkg::CODE_INSIDE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            post_v_reg <= '0;
        else if (en)
            post_v_reg <= {post_v_reg[0], st_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s17_reg   <= rti_pkg::sat_div(st_quot[0], st_sb.neg_s);
            t17_reg   <= rti_pkg::sat_div(st_quot[1], st_sb.neg_t);
            st17_reg  <= st_sb;
            res18_reg <= res18_next;
        end
    end

    // output register and skid word
    rti_pkg::result_t oq_reg;
    rti_pkg::result_t sk_reg;
    logic             push;
    logic             pop;

    assign push = post_v_reg[1] && en;
    assign pop  = oq_v_reg && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_v_reg <= 1'b0;
            sk_v_reg <= 1'b0;
        end
        else if (sk_v_reg)
        begin
            if (pop)
                sk_v_reg <= 1'b0;
        end
        else if (push)
        begin
            if (oq_v_reg && !pop)
                sk_v_reg <= 1'b1;
            else
                oq_v_reg <= 1'b1;
        end
        else if (pop)
            oq_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (sk_v_reg)
        begin
            if (pop)
                oq_reg <= sk_reg;
        end
        else if (push)
        begin
            if (oq_v_reg && !pop)
                sk_reg <= res18_reg;
            else
                oq_reg <= res18_reg;
        end
    end

    assign result_valid = oq_v_reg;
    assign result       = oq_reg;

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        sk_v_reg |-> oq_v_reg)
        else $error("skid word held with output register empty");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hit_code == rti_pkg::CODE_DEGEN) |->
        (result.hit_x == '0 && result.hit_y == '0 && result.hit_z == '0
         && result.param_s == '0 && result.param_t == '0))
        else $error("degenerate result carries non-zero fields");

    a_plane_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hit_code == rti_pkg::CODE_PLANE) |->
        (result.hit_x == '0 && result.param_s == '0 && result.param_t == '0))
        else $error("in-plane result carries a hit point");

    a_inside_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hit_code == rti_pkg::CODE_INSIDE) |->
        (!result.param_s[rti_pkg::Q_W-1] && !result.param_t[rti_pkg::Q_W-1]
         && result.param_s <= rti_pkg::ONE_Q && result.param_t <= rti_pkg::ONE_Q))
        else $error("inside result with s or t out of range");

endmodule

`default_nettype wire

### rtl/rti_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, LANES numerators
// over one shared denominator. Sideband word travels alongside.
module rti_div #(
    parameter int NUM_W = rti_pkg::DIV_NUM_W,
    parameter int DEN_W = rti_pkg::DIV_DEN_W,
    parameter int LANES = 1,
    parameter int SB_W  = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        valid,
    input  wire logic [LANES-1:0][NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0]            den,
    input  wire logic [SB_W-1:0]             sb,
    output logic                             done_valid,
    output logic [LANES-1:0][NUM_W-1:0]      quot,
    output logic [SB_W-1:0]                  done_sb
);

    logic [NUM_W-1:0]            v_reg;
    logic [LANES-1:0][DEN_W-1:0] rem_reg  [NUM_W];
    logic [LANES-1:0][NUM_W-1:0] q_reg    [NUM_W];
    logic [DEN_W-1:0]            den_reg  [NUM_W];
    logic [SB_W-1:0]             sb_reg   [NUM_W];

    logic [LANES-1:0][DEN_W-1:0] rem_in   [NUM_W];
    logic [LANES-1:0][NUM_W-1:0] q_in     [NUM_W];
    logic [DEN_W-1:0]            den_in   [NUM_W];
    logic [LANES-1:0][DEN_W-1:0] rem_next [NUM_W];
    logic [LANES-1:0][NUM_W-1:0] q_next   [NUM_W];

    always_comb
    begin
        rem_in[0] = '0;
        q_in[0]   = num;
        den_in[0] = den;
        for (int k = 1; k < NUM_W; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            q_in[k]   = q_reg[k-1];
            den_in[k] = den_reg[k-1];
        end
    end

    always_comb
    begin : step
        logic [DEN_W:0] shifted;
        logic [DEN_W:0] diff;
        for (int k = 0; k < NUM_W; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                shifted = {rem_in[k][l], q_in[k][l][NUM_W-1]};
                diff    = shifted - {1'b0, den_in[k]};
                q_next[k][l]   = {q_in[k][l][NUM_W-2:0], ~diff[DEN_W]};
                rem_next[k][l] = diff[DEN_W] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NUM_W-2:0], valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb;
            for (int k = 0; k < NUM_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                den_reg[k] <= den_in[k];
            end
            for (int k = 1; k < NUM_W; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    assign done_valid = v_reg[NUM_W-1];
    assign quot       = q_reg[NUM_W-1];
    assign done_sb    = sb_reg[NUM_W-1];

endmodule

`default_nettype wire

### sim/tb_ray_triangle_intersect.sv
`timescale 1ns / 1ps

module tb_ray_triangle_intersect;

    import rti_pkg::*;

    localparam longint UNIT = 65536;    // 1.0 in Q16.16

    // Ray/triangle predictor plus queue of expected result words
    class hit_scoreboard;
        longint  org[3];
        longint  dir[3];
        result_t pending[$];
        int      errors;

        function void set_reg(cfg_idx_t idx, q_t d);
            case (idx)
                REG_ORG_X: org[0] = d;
                REG_ORG_Y: org[1] = d;
                REG_ORG_Z: org[2] = d;
                REG_DIR_X: dir[0] = d;
                REG_DIR_Y: dir[1] = d;
                REG_DIR_Z: dir[2] = d;
                default: ;
            endcase
        endfunction

        function longint clamp(longint x);
            if (x > 64'sd2147483647)
                return 64'sd2147483647;
            if (x < -64'sd2147483648)
                return -64'sd2147483648;
            return x;
        endfunction

        function longint clamp_wide(logic signed [65:0] x);
            if (x > 66'sd2147483647)
                return 64'sd2147483647;
            if (x < -66'sd2147483648)
                return -64'sd2147483648;
            return longint'(x);
        endfunction

        // floored Q16.16 product
        function longint qmul(longint a, longint b);
            return (a * b) >>> 16;
        endfunction

        function longint qdiv(longint num, longint den);
            return clamp((num * UNIT) / den);
        endfunction

        function longint qdot(longint a0, longint a1, longint a2,
                              longint b0, longint b1, longint b2);
            return clamp(qmul(a0, b0) + qmul(a1, b1) + qmul(a2, b2));
        endfunction

        function result_t predict(face_t f);
            longint            p0[3], u[3], v[3], n[3], w0[3], w[3], hp[3];
            logic signed [65:0] ex[3];
            longint            a, b, r, uu, uv, vv, wu, wv, den, s, t;
            hit_code_t         code;
            result_t           res;
            p0[0] = f.vert0_x; p0[1] = f.vert0_y; p0[2] = f.vert0_z;
            u[0] = clamp(longint'(f.vert1_x) - p0[0]);
            u[1] = clamp(longint'(f.vert1_y) - p0[1]);
            u[2] = clamp(longint'(f.vert1_z) - p0[2]);
            v[0] = clamp(longint'(f.vert2_x) - p0[0]);
            v[1] = clamp(longint'(f.vert2_y) - p0[1]);
            v[2] = clamp(longint'(f.vert2_z) - p0[2]);
            hp = '{0, 0, 0};
            s = 0;
            t = 0;
            code = CODE_MISS;
            // exact normal, kept wide so the difference cannot wrap
            ex[0] = 66'(u[1] * v[2]) - 66'(u[2] * v[1]);
            ex[1] = 66'(u[2] * v[0]) - 66'(u[0] * v[2]);
            ex[2] = 66'(u[0] * v[1]) - 66'(u[1] * v[0]);
            if (ex[0] == 0 && ex[1] == 0 && ex[2] == 0)
                code = CODE_DEGEN;
            else begin
                for (int i = 0; i < 3; i++)
                begin
                    n[i]  = clamp_wide(ex[i] >>> 16);
                    w0[i] = clamp(org[i] - p0[i]);
                end
                a = clamp(-(qmul(n[0], w0[0]) + qmul(n[1], w0[1]) + qmul(n[2], w0[2])));
                b = qdot(n[0], n[1], n[2], dir[0], dir[1], dir[2]);
                if (b > -longint'(PAR_LIM) && b < longint'(PAR_LIM))
                    code = (a == 0) ? CODE_PLANE : CODE_MISS;
                else begin
                    r = qdiv(a, b);
                    if (r >= 0) begin
                        for (int i = 0; i < 3; i++)
                        begin
                            hp[i] = clamp(org[i] + qmul(r, dir[i]));
                            w[i]  = clamp(hp[i] - p0[i]);
                        end
                        uu  = qdot(u[0], u[1], u[2], u[0], u[1], u[2]);
                        uv  = qdot(u[0], u[1], u[2], v[0], v[1], v[2]);
                        vv  = qdot(v[0], v[1], v[2], v[0], v[1], v[2]);
                        wu  = qdot(w[0], w[1], w[2], u[0], u[1], u[2]);
                        wv  = qdot(w[0], w[1], w[2], v[0], v[1], v[2]);
                        den = clamp(qmul(uv, uv) - qmul(uu, vv));
                        if (den != 0) begin
                            s = qdiv(clamp(qmul(uv, wv) - qmul(vv, wu)), den);
                            if (s >= 0 && s <= UNIT) begin
                                t = qdiv(clamp(qmul(uv, wu) - qmul(uu, wv)), den);
                                if (t >= 0 && s + t <= UNIT)
                                    code = CODE_INSIDE;
                            end
                        end
                    end
                end
            end
            res.hit_code = code;
            res.hit_x    = q_t'(hp[0]);
            res.hit_y    = q_t'(hp[1]);
            res.hit_z    = q_t'(hp[2]);
            res.param_s  = q_t'(s);
            res.param_t  = q_t'(t);
            return res;
        endfunction

        function void note_face(face_t f);
            pending.push_back(predict(f));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word, got %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit_code !== want.hit_code) begin
                $display("%0t: hit_code exp %0d got %0d", $time, want.hit_code, got.hit_code);
                errors++;
            end
            if (got.hit_x !== want.hit_x) begin
                $display("%0t: hit_x exp %h got %h", $time, want.hit_x, got.hit_x);
                errors++;
            end
            if (got.hit_y !== want.hit_y) begin
                $display("%0t: hit_y exp %h got %h", $time, want.hit_y, got.hit_y);
                errors++;
            end
            if (got.hit_z !== want.hit_z) begin
                $display("%0t: hit_z exp %h got %h", $time, want.hit_z, got.hit_z);
                errors++;
            end
            if (got.param_s !== want.param_s) begin
                $display("%0t: param_s exp %h got %h", $time, want.param_s, got.param_s);
                errors++;
            end
            if (got.param_t !== want.param_t) begin
                $display("%0t: param_t exp %h got %h", $time, want.param_t, got.param_t);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [Q_W-1:0]       cfg_data;
    logic                 face_valid;
    logic                 face_ready;
    face_t                face;
    logic                 result_valid;
    logic                 result_ready;
    result_t              result;

    hit_scoreboard sb;
    int            send_idle;   // percent of items preceded by a gap
    int            recv_idle;   // percent of cycles with result_ready low

    ray_triangle_intersect u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .face_valid   (face_valid),
        .face_ready   (face_ready),
        .face         (face),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Consumer back-pressure
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Result words are sampled at the edge that accepts them
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    // Hard stop in case the pipeline hangs
    initial
    begin
        #4000000;
        $display("ray_triangle_intersect regression: fail");
        $finish;
    end

    // Ready is stable from the falling edge, so sampling there tells whether
    // the next rising edge takes the word.
    task automatic write_reg(cfg_idx_t idx, q_t d);
        logic ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end while (!ok);
        sb.set_reg(idx, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_ray(q_t ox, q_t oy, q_t oz, q_t dx, q_t dy, q_t dz);
        write_reg(REG_ORG_X, ox);
        write_reg(REG_ORG_Y, oy);
        write_reg(REG_ORG_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
    endtask

    task automatic send_face(face_t f);
        logic ok;
        if ($urandom_range(99) < send_idle) begin
            face_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        face       <= f;
        face_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            ok = face_ready;
            @(posedge clk);
        end while (!ok);
        sb.note_face(f);
    endtask

    task automatic drain();
        face_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then cover the pipeline depth before touching the ray
    task automatic settle();
        drain();
        repeat (130) @(posedge clk);
    endtask

    // Directed face, coordinates in whole units
    function automatic face_t unit_face(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz);
        face_t f;
        f.vert0_x = q_t'(ax * UNIT); f.vert0_y = q_t'(ay * UNIT); f.vert0_z = q_t'(az * UNIT);
        f.vert1_x = q_t'(bx * UNIT); f.vert1_y = q_t'(by * UNIT); f.vert1_z = q_t'(bz * UNIT);
        f.vert2_x = q_t'(cx * UNIT); f.vert2_y = q_t'(cy * UNIT); f.vert2_z = q_t'(cz * UNIT);
        return f;
    endfunction

    function automatic longint spread(longint m);
        return longint'($urandom_range(32'(2 * m))) - m;
    endfunction

    function automatic q_t to_q(longint x);
        return q_t'(sb.clamp(x));
    endfunction

    // Mostly triangles placed around a point on the ray, so that the later
    // stages (hit point, s and t) see real work; the rest degenerate,
    // in-plane or raw noise.
    function automatic face_t random_face();
        face_t  f;
        longint c[3];
        longint rr;
        int     kind;
        kind = $urandom_range(99);
        if (kind < 70) begin
            rr = longint'($urandom_range(20 * UNIT)) - ((kind < 7) ? 25 * UNIT : 0);
            for (int i = 0; i < 3; i++)
                c[i] = sb.org[i] + ((rr * sb.dir[i]) >>> 16);
            f.vert0_x = to_q(c[0] + spread(10 * UNIT));
            f.vert0_y = to_q(c[1] + spread(10 * UNIT));
            f.vert0_z = to_q(c[2] + spread(10 * UNIT));
            f.vert1_x = to_q(c[0] + spread(10 * UNIT));
            f.vert1_y = to_q(c[1] + spread(10 * UNIT));
            f.vert1_z = to_q(c[2] + spread(10 * UNIT));
            f.vert2_x = to_q(c[0] + spread(10 * UNIT));
            f.vert2_y = to_q(c[1] + spread(10 * UNIT));
            f.vert2_z = to_q(c[2] + spread(10 * UNIT));
        end
        else if (kind < 78) begin
            // collinear vertices
            for (int i = 0; i < 3; i++)
                c[i] = spread(5 * UNIT);
            f.vert0_x = to_q(sb.org[0]);
            f.vert0_y = to_q(sb.org[1]);
            f.vert0_z = to_q(sb.org[2]);
            f.vert1_x = to_q(sb.org[0] + c[0]);
            f.vert1_y = to_q(sb.org[1] + c[1]);
            f.vert1_z = to_q(sb.org[2] + c[2]);
            f.vert2_x = to_q(sb.org[0] + 2 * c[0]);
            f.vert2_y = to_q(sb.org[1] + 2 * c[1]);
            f.vert2_z = to_q(sb.org[2] + 2 * c[2]);
        end
        else if (kind < 88) begin
            // plane through the origin containing the ray
            rr = $urandom_range(1, 4);
            f.vert0_x = to_q(sb.org[0]);
            f.vert0_y = to_q(sb.org[1]);
            f.vert0_z = to_q(sb.org[2]);
            f.vert1_x = to_q(sb.org[0] + rr * sb.dir[0]);
            f.vert1_y = to_q(sb.org[1] + rr * sb.dir[1]);
            f.vert1_z = to_q(sb.org[2] + rr * sb.dir[2]);
            f.vert2_x = to_q(sb.org[0] + spread(10 * UNIT));
            f.vert2_y = to_q(sb.org[1] + spread(10 * UNIT));
            f.vert2_z = to_q(sb.org[2] + spread(10 * UNIT));
        end
        else begin
            f.vert0_x = $urandom; f.vert0_y = $urandom; f.vert0_z = $urandom;
            f.vert1_x = $urandom; f.vert1_y = $urandom; f.vert1_z = $urandom;
            f.vert2_x = $urandom; f.vert2_y = $urandom; f.vert2_z = $urandom;
        end
        return f;
    endfunction

    initial
    begin
        face_t f;
        sb           = new;
        sb.errors    = 0;
        sb.org       = '{0, 0, 0};
        sb.dir       = '{0, 0, 0};
        send_idle    = 0;
        recv_idle    = 0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        face_valid   = 1'b0;
        face         = '0;
        result_ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ray from z = -10 straight up, steep enough that a tiny
        // triangle still clears the parallel threshold.
        set_ray(0, 0, q_t'(-10 * UNIT), 0, 0, q_t'(1000 * UNIT));
        send_face(unit_face(-1, -1, 0,  3, -1, 0,  -1,  3, 0));   // inside
        send_face(unit_face( 1,  1, 0,  2,  1, 0,   1,  2, 0));   // s beyond edge
        send_face(unit_face( 0,  1, 0,  1,  1, 0,   0,  2, 0));   // t negative
        send_face(unit_face(-1, -1, 0,  0, -1, 0,  -1,  0, 0));   // s + t past one
        send_face(unit_face( 0,  0, 0,  0,  0, 0,   0,  0, 0));   // all vertices equal
        send_face(unit_face( 1,  2, 3,  2,  4, 6,   3,  6, 9));   // collinear
        send_face(unit_face( 5,  0, 0,  5,  1, 0,   5,  0, 1));   // parallel, off plane
        send_face(unit_face( 0,  0, 0,  1,  0, 0,   0,  0, 1));   // parallel, in plane
        send_face(unit_face(-1, -1, -20, 3, -1, -20, -1, 3, -20)); // behind origin
        // tiny triangle: normal survives, parametric denominator rounds to zero
        f = '0;
        f.vert1_x = 256;
        f.vert2_y = 256;
        send_face(f);
        // normal too small after rounding
        f.vert1_x = 1;
        f.vert2_y = 1;
        send_face(f);
        f = {9{Q_MAX}};
        send_face(f);
        f = {9{Q_MIN}};
        send_face(f);
        f = {Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX};
        send_face(f);
        f = {Q_MAX, Q_MIN, 32'sd0, Q_MIN, Q_MAX, 32'sd1, 32'sd0, 32'sd0, Q_MIN};
        send_face(f);
        settle();

        // Random phases, each with its own ray; extremes in phases 2 and 3
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                2:       set_ray(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
                3:       set_ray(q_t'(spread(50 * UNIT)), q_t'(spread(50 * UNIT)),
                                 q_t'(spread(50 * UNIT)), 0, 0, 0);
                default: set_ray(q_t'(spread(50 * UNIT)), q_t'(spread(50 * UNIT)),
                                 q_t'(spread(50 * UNIT)), q_t'(spread(2 * UNIT)),
                                 q_t'(spread(2 * UNIT)), q_t'(spread(2 * UNIT)));
            endcase
            send_idle = (ph < 2) ? 16 : (ph < 4) ? 87 : 0;
            recv_idle = (ph < 2) ? 87 : (ph < 4) ? 16 : 0;
            for (int k = 0; k < 131; k++)
            begin
                send_face(random_face());
                if (ph == 0 && k == 60)
                    drain();
            end
            settle();
        end

        if (sb.errors == 0)
            $display("ray_triangle_intersect regression: pass");
        else
            $display("ray_triangle_intersect regression: fail");
        $finish;
    end

endmodule
